FILE: rtl/scf_pkg.sv
// Shared types and constants for the sum-checked frame receiver.
package scf_pkg;

   // Byte position saturates here; later bytes of a burst are ignored
   localparam int unsigned PosLimit  = 259;
   localparam int unsigned PosWidth  = 9;
   localparam int unsigned MinLength = 3;

   // Defaults for the top-level parameters
   localparam int unsigned DefaultHeaderReset = 0;
   localparam int unsigned DefaultBufDepth    = 2;

   // Frame status codes reported with each burst
   typedef enum logic [2:0] {
      STATUS_OK        = 3'd0,
      STATUS_BAD_HDR   = 3'd1,
      STATUS_SHORT_LEN = 3'd2,
      STATUS_SUM_ERR   = 3'd3,
      STATUS_EARLY_END = 3'd4
   } status_type;

   // One result beat before packing onto the stream
   typedef struct packed {
      logic [15:0] computed_sum;
      logic [7:0]  first_payload;
      logic [7:0]  length_field;
      logic [7:0]  command_code;
      status_type  frame_status;
   } result_type;

   localparam int unsigned ResultWidth = $bits(result_type);
   localparam int unsigned RspDataWidth = ((ResultWidth + 7) / 8) * 8;

endpackage

FILE: rtl/scf_frame_track.sv
// Per-byte frame tracker: position, running sum, held fields and status.
module scf_frame_track (
   input  logic                clock,
   input  logic                reset,
   input  logic                beat_valid,
   input  logic [7:0]          rx_byte,
   input  logic                burst_end,
   input  logic [7:0]          header_value,
   output logic                res_valid,
   output scf_pkg::result_type res
);

   localparam logic [scf_pkg::PosWidth-1:0] PosMax =
      scf_pkg::PosWidth'(scf_pkg::PosLimit);
   localparam logic [scf_pkg::PosWidth:0] MinLenW =
      (scf_pkg::PosWidth + 1)'(scf_pkg::MinLength);

   logic [scf_pkg::PosWidth-1:0] pos_ff, pos_in;
   logic [15:0]                  sum_ff, sum_in;
   logic [7:0]                   len_ff, len_in;
   logic [7:0]                   cmd_ff, cmd_in;
   logic [7:0]                   pay_ff, pay_in;
   logic [7:0]                   sum_hi_ff, sum_hi_in;
   logic                         hdr_bad_ff, hdr_bad_in;
   logic                         sum_bad_ff, sum_bad_in;

   // Updated values after this beat, before any clear at burst end
   logic [scf_pkg::PosWidth-1:0] pos_nx;
   logic [15:0]                  sum_nx;
   logic [7:0]                   len_nx, cmd_nx, pay_nx, sum_hi_nx;
   logic                         hdr_bad_nx, sum_bad_nx;
   logic [scf_pkg::PosWidth:0]   pos_w, len_w;
   logic                         active;
   scf_pkg::status_type          status;

   // Fold one byte into the frame state
   always_comb begin
      active     = (pos_ff < PosMax);
      pos_nx     = pos_ff;
      sum_nx     = sum_ff;
      len_nx     = len_ff;
      cmd_nx     = cmd_ff;
      pay_nx     = pay_ff;
      sum_hi_nx  = sum_hi_ff;
      hdr_bad_nx = hdr_bad_ff;
      sum_bad_nx = sum_bad_ff;
      pos_w      = {1'b0, pos_ff};
      if (active) begin
         if (pos_ff <= 9'd1 && rx_byte != header_value) begin
            hdr_bad_nx = 1'b1;
         end
         if (pos_ff == 9'd2) begin
            len_nx = rx_byte;
         end
         if (pos_ff == 9'd3) begin
            cmd_nx = rx_byte;
         end
         if (pos_ff == 9'd4) begin
            pay_nx = rx_byte;
         end
         if (pos_ff <= 9'd2 || pos_ff <= {1'b0, len_nx}) begin
            sum_nx = sum_ff + {8'd0, rx_byte};
         end
         if (pos_ff >= 9'd3 && pos_w == {2'b00, len_nx} + 10'd1) begin
            sum_hi_nx = rx_byte;
         end
         if (pos_ff >= 9'd3 && pos_w == {2'b00, len_nx} + 10'd2) begin
            sum_bad_nx = ({sum_hi_ff, rx_byte} != sum_nx);
         end
         pos_nx = pos_ff + 9'd1;
      end
   end

   // Judge the burst in priority order
   always_comb begin
      len_w = {2'b00, len_nx};
      priority if (hdr_bad_nx) begin
         status = scf_pkg::STATUS_BAD_HDR;
      end else if (pos_nx < 9'd3) begin
         status = scf_pkg::STATUS_EARLY_END;
      end else if (len_w < MinLenW) begin
         status = scf_pkg::STATUS_SHORT_LEN;
      end else if ({1'b0, pos_nx} < len_w + 10'd3) begin
         status = scf_pkg::STATUS_EARLY_END;
      end else if (sum_bad_nx) begin
         status = scf_pkg::STATUS_SUM_ERR;
      end else begin
         status = scf_pkg::STATUS_OK;
      end
   end

   assign res_valid         = beat_valid & burst_end;
   assign res.frame_status  = status;
   assign res.command_code  = cmd_nx;
   assign res.length_field  = len_nx;
   assign res.first_payload = pay_nx;
   assign res.computed_sum  = sum_nx;

   // Advance on each beat; clear at burst end
   always_comb begin
      pos_in     = pos_ff;
      sum_in     = sum_ff;
      len_in     = len_ff;
      cmd_in     = cmd_ff;
      pay_in     = pay_ff;
      sum_hi_in  = sum_hi_ff;
      hdr_bad_in = hdr_bad_ff;
      sum_bad_in = sum_bad_ff;
      if (beat_valid) begin
         if (burst_end) begin
            pos_in     = '0;
            sum_in     = '0;
            len_in     = '0;
            cmd_in     = '0;
            pay_in     = '0;
            sum_hi_in  = '0;
            hdr_bad_in = 1'b0;
            sum_bad_in = 1'b0;
         end else begin
            pos_in     = pos_nx;
            sum_in     = sum_nx;
            len_in     = len_nx;
            cmd_in     = cmd_nx;
            pay_in     = pay_nx;
            sum_hi_in  = sum_hi_nx;
            hdr_bad_in = hdr_bad_nx;
            sum_bad_in = sum_bad_nx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         sum_ff     <= '0;
         len_ff     <= '0;
         cmd_ff     <= '0;
         pay_ff     <= '0;
         sum_hi_ff  <= '0;
         hdr_bad_ff <= 1'b0;
         sum_bad_ff <= 1'b0;
      end else begin
         pos_ff     <= pos_in;
         sum_ff     <= sum_in;
         len_ff     <= len_in;
         cmd_ff     <= cmd_in;
         pay_ff     <= pay_in;
         sum_hi_ff  <= sum_hi_in;
         hdr_bad_ff <= hdr_bad_in;
         sum_bad_ff <= sum_bad_in;
      end
   end

endmodule

FILE: rtl/scf_out_buf.sv
// Small result buffer that decouples the result stream from the input side.
module scf_out_buf #(
   parameter int unsigned Depth = scf_pkg::DefaultBufDepth
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  scf_pkg::result_type push_data,
   output logic                has_room,
   output logic                out_valid,
   input  logic                out_ready,
   output scf_pkg::result_type out_data
);

   localparam int unsigned PtrWidth = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int unsigned CntWidth = $clog2(Depth + 1);
   localparam logic [CntWidth-1:0] DepthC = CntWidth'(Depth);
   localparam logic [PtrWidth-1:0] LastC  = PtrWidth'(Depth - 1);

   scf_pkg::result_type     slot_ff [Depth];
   logic [PtrWidth-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0]     count_ff, count_in;
   logic                    pop;

   assign has_room  = (count_ff != DepthC);
   assign out_valid = (count_ff != '0);
   assign pop       = out_valid & out_ready;
   assign out_data  = slot_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LastC) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LastC) ? '0 : rd_ptr_ff + 1'b1;
      end
      unique case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Hold result payload
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: rtl/sum_checked_frame_receiver_top.sv
// Top level of the sum-checked frame receiver.
//
//   channel   direction  handshake            payload
//   req_*     in         req_tvalid/tready    tdata = rx_byte, tlast = burst_end
//   rsp_*     out        rsp_tvalid/tready    tdata = status, cmd, len, payload, sum
//   csr_*     in         csr_valid/ready      csr_wdata = header_value
//
// One byte is accepted per cycle while the result buffer has room; the frame
// tracker updates position and running sum in the same cycle the beat is taken.
// Each result beat is written into the result buffer and leaves on rsp_* in order.
// req_tready drops only while the result buffer is full (Depth results waiting).
// Synchronous active-high reset clears frame and buffer state; header_value takes HeaderReset.
module sum_checked_frame_receiver_top #(
   parameter int unsigned HeaderReset = scf_pkg::DefaultHeaderReset,
   parameter int unsigned BufDepth    = scf_pkg::DefaultBufDepth
) (
   input  logic                             clock,
   input  logic                             reset,
   // bits [7:0] rx_byte
   input  logic [7:0]                       req_tdata,
   input  logic                             req_tlast,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // bits [2:0] frame_status, [10:3] command_code, [18:11] length_field,
   // [26:19] first_payload, [42:27] computed_sum, [47:43] zero
   output logic [scf_pkg::RspDataWidth-1:0] rsp_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic [7:0]                       csr_wdata,
   input  logic                             csr_valid,
   output logic                             csr_ready
);

   logic [7:0]          header_ff, header_in;
   logic                has_room;
   logic                beat;
   logic                res_valid;
   scf_pkg::result_type res;
   scf_pkg::result_type rsp_res;

   assign csr_ready  = 1'b1;
   assign req_tready = has_room;
   assign beat       = req_tvalid & has_room;

   // Take header value writes
   always_comb begin
      header_in = header_ff;
      if (csr_valid) begin
         header_in = csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         header_ff <= 8'(HeaderReset);
      end else begin
         header_ff <= header_in;
      end
   end

   scf_frame_track u_track (
      .clock        (clock),
      .reset        (reset),
      .beat_valid   (beat),
      .rx_byte      (req_tdata),
      .burst_end    (req_tlast),
      .header_value (header_ff),
      .res_valid    (res_valid),
      .res          (res)
   );

   scf_out_buf #(
      .Depth (BufDepth)
   ) u_out (
      .clock     (clock),
      .reset     (reset),
      .push      (res_valid),
      .push_data (res),
      .has_room  (has_room),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_res)
   );

   // Pack the result beat, zero filled to whole bytes
   assign rsp_tdata = scf_pkg::RspDataWidth'(rsp_res);

endmodule
